// ===== rtl/mailbox_message_queue_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Mailbox message queue engine assertion macros
// Implication checks on the engine clock, held off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_MESSAGE_QUEUE_ENGINE_ASSERT_SVH
`define MAILBOX_MESSAGE_QUEUE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define MMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox engine check failed");

// Next-cycle implication.
`define MMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox engine check failed");

`endif

// ===== rtl/mmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Mailbox message queue engine package
// Sizes, descriptor and entry layouts, codes and address helpers.
// ----------------------------------------------------------------------------
package mmq_pkg;

    localparam int MAILBOXES  = 4;
    localparam int RING_DEPTH = 16;
    localparam int PROCESSES  = 32;

    localparam int PID_W  = 5;
    localparam int MB_W   = 3;
    localparam int DATA_W = 32;

    localparam int MB_AW   = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1;
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int WPTR_W  = $clog2(PROCESSES);
    localparam int WCNT_W  = $clog2(PROCESSES + 1);
    localparam int MSG_DEPTH = MAILBOXES * RING_DEPTH;
    localparam int WT_DEPTH  = MAILBOXES * PROCESSES;
    localparam int MSG_AW  = $clog2(MSG_DEPTH);
    localparam int WT_AW   = $clog2(WT_DEPTH);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 112;
    localparam int M_PAD_W   = M_TDATA_W - (2 * PID_W + 3 * DATA_W);

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_DELIVERED = 3'd1,
        ST_FULL      = 3'd2,
        ST_RECEIVED  = 3'd3,
        ST_BLOCKED   = 3'd4,
        ST_WAITFULL  = 3'd5,
        ST_BADBOX    = 3'd6
    } t_status;

    typedef enum logic [0:0] {
        CMD_SEND = 1'b0,
        CMD_RECV = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DESC,
        S_READ_WT,
        S_READ_MSG,
        S_EMIT
    } t_state;

    // Per-mailbox ring and waiter pointers, one descriptor memory entry.
    typedef struct packed {
        logic [PTR_W-1:0]  msg_head;
        logic [PTR_W-1:0]  msg_tail;
        logic [CNT_W-1:0]  msg_count;
        logic [WPTR_W-1:0] wt_head;
        logic [WPTR_W-1:0] wt_tail;
        logic [WCNT_W-1:0] wt_count;
    } t_desc;

    typedef struct packed {
        logic [PID_W-1:0]  sender;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] stamp;
    } t_msg;

    typedef struct packed {
        t_status           status;
        logic [PID_W-1:0]  target;
        logic [PID_W-1:0]  sender;
        logic [DATA_W-1:0] payload;
        logic [DATA_W-1:0] post_stamp;
        logic [DATA_W-1:0] time_recv;
    } t_result;

    function automatic logic [PTR_W-1:0] msg_ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [WPTR_W-1:0] wt_ptr_inc(input logic [WPTR_W-1:0] p);
        return (p == WPTR_W'(PROCESSES - 1)) ? '0 : p + WPTR_W'(1);
    endfunction

    function automatic logic [MSG_AW-1:0] msg_addr(input logic [MB_AW-1:0] mb,
                                                   input logic [PTR_W-1:0] p);
        return MSG_AW'(int'(mb) * RING_DEPTH + int'(p));
    endfunction

    function automatic logic [WT_AW-1:0] wt_addr(input logic [MB_AW-1:0] mb,
                                                 input logic [WPTR_W-1:0] p);
        return WT_AW'(int'(mb) * PROCESSES + int'(p));
    endfunction

endpackage

// ===== rtl/mmq_ram.sv =====
// ----------------------------------------------------------------------------
// Mailbox engine RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mailbox_message_queue_engine.sv =====
// ----------------------------------------------------------------------------
// Mailbox message queue engine
// Each request reads its mailbox descriptor, updates the message ring or the
// waiter FIFO in memory and returns one status word.
// ----------------------------------------------------------------------------
// A request word is taken only while the engine is idle and out of reset, and
// then occupies it for the accepting cycle, in which the mailbox descriptor
// memory is read, then S_DESC to decide and write it back, then S_READ_MSG or
// S_READ_WT to read the message ring or waiter memory when a message goes out
// (delivered, received; not for queued, full, blocked, wait-full, bad mailbox),
// and S_EMIT to load the output register. The engine is ready again in the
// cycle after that, so it takes no new request before the last one has been
// loaded into the output register. A finished result waits in the output
// register; the next request is still taken and only stalls once its own
// result needs that register. Descriptors start out empty after reset through
// a valid bit per mailbox; no clearing pass is needed.
`include "mailbox_message_queue_engine_assert.svh"

module mailbox_message_queue_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // requester_pid, mailbox, payload, time_now
    input  logic [mmq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // target_pid, msg_origin, msg_payload, msg_post_stamp, msg_time_received
    output logic [mmq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status
    output logic [2:0]                     m_axis_tuser
);

    mmq_pkg::t_state  r_state, n_state;

    logic                            r_cmd;
    logic [mmq_pkg::PID_W-1:0]       r_pid;
    logic [mmq_pkg::MB_W-1:0]        r_mb;
    logic [mmq_pkg::DATA_W-1:0]      r_payload;
    logic [mmq_pkg::DATA_W-1:0]      r_time;
    logic                            r_bad;
    logic [mmq_pkg::MAILBOXES-1:0]   r_desc_vld;
    mmq_pkg::t_result                r_res, n_res;
    mmq_pkg::t_result                r_out;
    logic                            r_out_vld;

    logic                            w_accept;
    logic [mmq_pkg::MB_W-1:0]        w_in_mb;
    logic                            w_in_bad;
    logic [mmq_pkg::MB_AW-1:0]       w_mb_idx;

    logic                            w_desc_we;
    mmq_pkg::t_desc                  w_desc_rdata, w_desc, w_desc_wdata;
    logic                            w_msg_we, w_msg_re;
    logic [mmq_pkg::MSG_AW-1:0]      w_msg_waddr, w_msg_raddr;
    mmq_pkg::t_msg                   w_msg_wdata, w_msg_rdata;
    logic                            w_wt_we, w_wt_re;
    logic [mmq_pkg::WT_AW-1:0]       w_wt_waddr, w_wt_raddr;
    logic [mmq_pkg::PID_W-1:0]       w_wt_rdata;
    logic                            w_out_load;

    assign s_axis_tready = i_rst_n && (r_state == mmq_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_mb       = s_axis_tdata[7:5];
    assign w_in_bad      = ({1'b0, w_in_mb} >= 4'(mmq_pkg::MAILBOXES));
    assign w_mb_idx      = r_mb[mmq_pkg::MB_AW-1:0];

    // A mailbox never written since reset reads as an empty descriptor.
    assign w_desc = r_desc_vld[w_mb_idx] ? w_desc_rdata : '0;

    mmq_ram #(
        .WIDTH ($bits(mmq_pkg::t_desc)),
        .DEPTH (mmq_pkg::MAILBOXES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (w_mb_idx),
        .i_wdata (w_desc_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_mb[mmq_pkg::MB_AW-1:0]),
        .o_rdata (w_desc_rdata)
    );

    mmq_ram #(
        .WIDTH ($bits(mmq_pkg::t_msg)),
        .DEPTH (mmq_pkg::MSG_DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (w_msg_we),
        .i_waddr (w_msg_waddr),
        .i_wdata (w_msg_wdata),
        .i_re    (w_msg_re),
        .i_raddr (w_msg_raddr),
        .o_rdata (w_msg_rdata)
    );

    mmq_ram #(
        .WIDTH (mmq_pkg::PID_W),
        .DEPTH (mmq_pkg::WT_DEPTH)
    ) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wt_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (r_pid),
        .i_re    (w_wt_re),
        .i_raddr (w_wt_raddr),
        .o_rdata (w_wt_rdata)
    );

    assign w_msg_waddr = mmq_pkg::msg_addr(w_mb_idx, w_desc.msg_tail);
    assign w_msg_raddr = mmq_pkg::msg_addr(w_mb_idx, w_desc.msg_head);
    assign w_wt_waddr  = mmq_pkg::wt_addr(w_mb_idx, w_desc.wt_tail);
    assign w_wt_raddr  = mmq_pkg::wt_addr(w_mb_idx, w_desc.wt_head);
    assign w_msg_wdata = '{sender: r_pid, payload: r_payload, stamp: r_time};

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        w_desc_we    = 1'b0;
        w_desc_wdata = w_desc;
        w_msg_we     = 1'b0;
        w_msg_re     = 1'b0;
        w_wt_we      = 1'b0;
        w_wt_re      = 1'b0;
        w_out_load   = 1'b0;

        case (r_state)
            mmq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = mmq_pkg::S_DESC;
                end
            end
            mmq_pkg::S_DESC: begin
                n_res   = '0;
                n_state = mmq_pkg::S_EMIT;
                if (r_bad) begin
                    n_res.status = mmq_pkg::ST_BADBOX;
                end else if (r_cmd == mmq_pkg::CMD_SEND) begin
                    if (w_desc.msg_count == mmq_pkg::CNT_W'(mmq_pkg::RING_DEPTH)) begin
                        n_res.status = mmq_pkg::ST_FULL;
                    end else if (w_desc.wt_count != '0) begin
                        // Waiters exist only while the ring is empty, so the
                        // oldest message is this one and the ring is untouched.
                        w_wt_re              = 1'b1;
                        w_desc_we            = 1'b1;
                        w_desc_wdata.wt_head = mmq_pkg::wt_ptr_inc(w_desc.wt_head);
                        w_desc_wdata.wt_count = w_desc.wt_count - mmq_pkg::WCNT_W'(1);
                        n_res.status     = mmq_pkg::ST_DELIVERED;
                        n_res.sender     = r_pid;
                        n_res.payload    = r_payload;
                        n_res.post_stamp = r_time;
                        n_res.time_recv  = r_time;
                        n_state          = mmq_pkg::S_READ_WT;
                    end else begin
                        w_msg_we               = 1'b1;
                        w_desc_we              = 1'b1;
                        w_desc_wdata.msg_tail  = mmq_pkg::msg_ptr_inc(w_desc.msg_tail);
                        w_desc_wdata.msg_count = w_desc.msg_count + mmq_pkg::CNT_W'(1);
                        n_res.status           = mmq_pkg::ST_QUEUED;
                    end
                end else begin
                    if (w_desc.msg_count != '0) begin
                        w_msg_re               = 1'b1;
                        w_desc_we              = 1'b1;
                        w_desc_wdata.msg_head  = mmq_pkg::msg_ptr_inc(w_desc.msg_head);
                        w_desc_wdata.msg_count = w_desc.msg_count - mmq_pkg::CNT_W'(1);
                        n_res.status    = mmq_pkg::ST_RECEIVED;
                        n_res.target    = r_pid;
                        n_res.time_recv = r_time;
                        n_state         = mmq_pkg::S_READ_MSG;
                    end else if (w_desc.wt_count ==
                                 mmq_pkg::WCNT_W'(mmq_pkg::PROCESSES)) begin
                        n_res.status = mmq_pkg::ST_WAITFULL;
                    end else begin
                        w_wt_we               = 1'b1;
                        w_desc_we             = 1'b1;
                        w_desc_wdata.wt_tail  = mmq_pkg::wt_ptr_inc(w_desc.wt_tail);
                        w_desc_wdata.wt_count = w_desc.wt_count + mmq_pkg::WCNT_W'(1);
                        n_res.status          = mmq_pkg::ST_BLOCKED;
                    end
                end
            end
            mmq_pkg::S_READ_WT: begin
                n_res.target = w_wt_rdata;
                n_state      = mmq_pkg::S_EMIT;
            end
            mmq_pkg::S_READ_MSG: begin
                n_res.sender     = w_msg_rdata.sender;
                n_res.payload    = w_msg_rdata.payload;
                n_res.post_stamp = w_msg_rdata.stamp;
                n_state          = mmq_pkg::S_EMIT;
            end
            mmq_pkg::S_EMIT: begin
                if (!r_out_vld || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = mmq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mmq_pkg::S_IDLE;
            r_desc_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_desc_we) begin
                r_desc_vld[w_mb_idx] <= 1'b1;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= s_axis_tuser;
            r_pid     <= s_axis_tdata[4:0];
            r_mb      <= w_in_mb;
            r_payload <= s_axis_tdata[39:8];
            r_time    <= s_axis_tdata[71:40];
            r_bad     <= w_in_bad;
        end
        r_res <= n_res;
        if (w_out_load) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {{mmq_pkg::M_PAD_W{1'b0}}, r_out.time_recv, r_out.post_stamp,
                            r_out.payload, r_out.sender, r_out.target};

    // An accepted request always goes on to the descriptor lookup.
    `MMQ_ASSERT_NEXT(a_accept_to_desc, i_clk, i_rst_n, w_accept, r_state == mmq_pkg::S_DESC)

    // The ring fill never exceeds its depth.
    `MMQ_ASSERT_NOW(a_ring_bound, i_clk, i_rst_n, (r_state == mmq_pkg::S_DESC) && !r_bad, w_desc.msg_count <= mmq_pkg::CNT_W'(mmq_pkg::RING_DEPTH))

    // Receivers wait only on an empty ring.
    `MMQ_ASSERT_NOW(a_wait_empty, i_clk, i_rst_n, (r_state == mmq_pkg::S_DESC) && !r_bad, (w_desc.wt_count == '0) || (w_desc.msg_count == '0))

    // Results without a delivered message carry all-zero data.
    `MMQ_ASSERT_NOW(a_nodata_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != mmq_pkg::ST_DELIVERED) && (m_axis_tuser != mmq_pkg::ST_RECEIVED), m_axis_tdata == '0)

endmodule

// ===== sim/mmq_result_checker.sv =====
// ----------------------------------------------------------------------------
// Mailbox engine result checker
// Watches the request and result streams of the mailbox engine, keeps its own
// copy of the mailbox rings and waiter queues, and compares every result word
// with the oldest predicted one, field by field.
// ----------------------------------------------------------------------------
module mmq_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    // requester_pid, mailbox, payload, time_now
    input  logic [mmq_pkg::S_TDATA_W-1:0]  i_req_data,
    // cmd
    input  logic                           i_req_user,
    input  logic                           i_rsp_valid,
    input  logic                           i_rsp_ready,
    // target_pid, msg_origin, msg_payload, msg_post_stamp, msg_time_received
    input  logic [mmq_pkg::M_TDATA_W-1:0]  i_rsp_data,
    // status
    input  logic [2:0]                     i_rsp_user,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output logic [7:0]                     o_status_seen
);

    // Predicted mailbox state.
    logic [mmq_pkg::PTR_W-1:0]  ring_rd      [mmq_pkg::MAILBOXES];
    logic [mmq_pkg::PTR_W-1:0]  ring_wr      [mmq_pkg::MAILBOXES];
    logic [mmq_pkg::CNT_W-1:0]  ring_fill    [mmq_pkg::MAILBOXES];
    logic [mmq_pkg::WPTR_W-1:0] wait_rd      [mmq_pkg::MAILBOXES];
    logic [mmq_pkg::WPTR_W-1:0] wait_wr      [mmq_pkg::MAILBOXES];
    logic [mmq_pkg::WCNT_W-1:0] wait_fill    [mmq_pkg::MAILBOXES];
    logic [mmq_pkg::DATA_W-1:0] ring_payload [mmq_pkg::MSG_DEPTH];
    logic [mmq_pkg::PID_W-1:0]  ring_sender  [mmq_pkg::MSG_DEPTH];
    logic [mmq_pkg::DATA_W-1:0] ring_stamp   [mmq_pkg::MSG_DEPTH];
    logic [mmq_pkg::PID_W-1:0]  waiter_pid   [mmq_pkg::WT_DEPTH];

    mmq_pkg::t_result expected_results[$];
    mmq_pkg::t_result got_word;
    mmq_pkg::t_result want_word;
    int               fails;
    int               checked;
    logic [7:0]       status_seen;

    // Pops the oldest message of a mailbox that is known to hold one.
    function automatic void deliver_oldest(input int box,
                                           input logic [mmq_pkg::PID_W-1:0] to_pid,
                                           input logic [mmq_pkg::DATA_W-1:0] now,
                                           inout mmq_pkg::t_result r);
        int slot;
        slot         = box * mmq_pkg::RING_DEPTH + int'(ring_rd[box]);
        r.target     = to_pid;
        r.sender     = ring_sender[slot];
        r.payload    = ring_payload[slot];
        r.post_stamp = ring_stamp[slot];
        r.time_recv  = now;
        ring_rd[box] = (ring_rd[box] == mmq_pkg::PTR_W'(mmq_pkg::RING_DEPTH - 1)) ? '0
                       : ring_rd[box] + mmq_pkg::PTR_W'(1);
        ring_fill[box] = ring_fill[box] - mmq_pkg::CNT_W'(1);
    endfunction

    function automatic mmq_pkg::t_result predict_mailbox_op(
            input mmq_pkg::t_cmd op,
            input logic [mmq_pkg::PID_W-1:0] pid,
            input logic [mmq_pkg::MB_W-1:0] mb,
            input logic [mmq_pkg::DATA_W-1:0] data,
            input logic [mmq_pkg::DATA_W-1:0] now);
        mmq_pkg::t_result r;
        int box;
        int slot;
        logic [mmq_pkg::PID_W-1:0] woken;
        r = '0;
        if (int'(mb) >= mmq_pkg::MAILBOXES) begin
            r.status = mmq_pkg::ST_BADBOX;
            return r;
        end
        box = int'(mb);
        if (op == mmq_pkg::CMD_SEND) begin
            if (int'(ring_fill[box]) >= mmq_pkg::RING_DEPTH) begin
                r.status = mmq_pkg::ST_FULL;
                return r;
            end
            slot = box * mmq_pkg::RING_DEPTH + int'(ring_wr[box]);
            ring_payload[slot] = data;
            ring_sender[slot]  = pid;
            ring_stamp[slot]   = now;
            ring_wr[box] = (ring_wr[box] == mmq_pkg::PTR_W'(mmq_pkg::RING_DEPTH - 1)) ? '0
                           : ring_wr[box] + mmq_pkg::PTR_W'(1);
            ring_fill[box] = ring_fill[box] + mmq_pkg::CNT_W'(1);
            // The new word lands in the ring first; a waiter then gets the oldest one.
            if (wait_fill[box] != '0) begin
                woken = waiter_pid[box * mmq_pkg::PROCESSES + int'(wait_rd[box])];
                wait_rd[box] = (wait_rd[box] == mmq_pkg::WPTR_W'(mmq_pkg::PROCESSES - 1))
                               ? '0 : wait_rd[box] + mmq_pkg::WPTR_W'(1);
                wait_fill[box] = wait_fill[box] - mmq_pkg::WCNT_W'(1);
                deliver_oldest(box, woken, now, r);
                r.status = mmq_pkg::ST_DELIVERED;
            end else begin
                r.status = mmq_pkg::ST_QUEUED;
            end
            return r;
        end
        if (ring_fill[box] != '0) begin
            deliver_oldest(box, pid, now, r);
            r.status = mmq_pkg::ST_RECEIVED;
        end else if (int'(wait_fill[box]) >= mmq_pkg::PROCESSES) begin
            r.status = mmq_pkg::ST_WAITFULL;
        end else begin
            waiter_pid[box * mmq_pkg::PROCESSES + int'(wait_wr[box])] = pid;
            wait_wr[box] = (wait_wr[box] == mmq_pkg::WPTR_W'(mmq_pkg::PROCESSES - 1)) ? '0
                           : wait_wr[box] + mmq_pkg::WPTR_W'(1);
            wait_fill[box] = wait_fill[box] + mmq_pkg::WCNT_W'(1);
            r.status = mmq_pkg::ST_BLOCKED;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: result word %0d: %s", checked, msg);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < mmq_pkg::MAILBOXES; b++) begin
                ring_rd[b]   = '0;
                ring_wr[b]   = '0;
                ring_fill[b] = '0;
                wait_rd[b]   = '0;
                wait_wr[b]   = '0;
                wait_fill[b] = '0;
            end
            foreach (ring_payload[i]) begin
                ring_payload[i] = '0;
                ring_sender[i]  = '0;
                ring_stamp[i]   = '0;
            end
            foreach (waiter_pid[i]) waiter_pid[i] = '0;
            expected_results.delete();
            fails       = 0;
            checked     = 0;
            status_seen = '0;
        end else begin
            // Results are matched before the request of the same edge is queued.
            if (i_rsp_valid && i_rsp_ready) begin
                got_word.status     = mmq_pkg::t_status'(i_rsp_user);
                got_word.target     = i_rsp_data[mmq_pkg::PID_W-1:0];
                got_word.sender     = i_rsp_data[mmq_pkg::PID_W +: mmq_pkg::PID_W];
                got_word.payload    = i_rsp_data[2*mmq_pkg::PID_W +: mmq_pkg::DATA_W];
                got_word.post_stamp = i_rsp_data[2*mmq_pkg::PID_W+mmq_pkg::DATA_W
                                                 +: mmq_pkg::DATA_W];
                got_word.time_recv  = i_rsp_data[2*mmq_pkg::PID_W+2*mmq_pkg::DATA_W
                                                 +: mmq_pkg::DATA_W];
                status_seen[i_rsp_user] = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with status %0d but none expected",
                                              i_rsp_user));
                end else begin
                    want_word = expected_results.pop_front();
                    if (got_word.status != want_word.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got_word.status, want_word.status));
                    if (got_word.target != want_word.target)
                        report_mismatch($sformatf("target_pid %0d, expected %0d",
                                                  got_word.target, want_word.target));
                    if (got_word.sender != want_word.sender)
                        report_mismatch($sformatf("msg_origin %0d, expected %0d",
                                                  got_word.sender, want_word.sender));
                    if (got_word.payload != want_word.payload)
                        report_mismatch($sformatf("msg_payload 0x%08h, expected 0x%08h",
                                                  got_word.payload, want_word.payload));
                    if (got_word.post_stamp != want_word.post_stamp)
                        report_mismatch($sformatf("msg_post_stamp 0x%08h, expected 0x%08h",
                                                  got_word.post_stamp,
                                                  want_word.post_stamp));
                    if (got_word.time_recv != want_word.time_recv)
                        report_mismatch($sformatf("msg_time_received 0x%08h, expected 0x%08h",
                                                  got_word.time_recv, want_word.time_recv));
                    if (i_rsp_data[mmq_pkg::M_TDATA_W-1 -: mmq_pkg::M_PAD_W] != '0)
                        report_mismatch("padding bits of the result word are not zero");
                end
                checked++;
            end
            if (i_req_valid && i_req_ready)
                expected_results.push_back(predict_mailbox_op(
                    mmq_pkg::t_cmd'(i_req_user),
                    i_req_data[mmq_pkg::PID_W-1:0],
                    i_req_data[mmq_pkg::PID_W +: mmq_pkg::MB_W],
                    i_req_data[mmq_pkg::PID_W+mmq_pkg::MB_W +: mmq_pkg::DATA_W],
                    i_req_data[mmq_pkg::PID_W+mmq_pkg::MB_W+mmq_pkg::DATA_W
                               +: mmq_pkg::DATA_W]));
        end
        o_pending     <= expected_results.size();
        o_fail_count  <= fails;
        o_checked     <= checked;
        o_status_seen <= status_seen;
    end

endmodule

// ===== sim/tb_mailbox_message_queue_engine.sv =====
// ----------------------------------------------------------------------------
// Mailbox message queue engine testbench
// Drives directed and random send/receive requests under three idling mixes
// on both streams; the result checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_mailbox_message_queue_engine;

    localparam int RESET_CYCLES    = 12;
    localparam int WORDS_PER_PHASE = 450;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 400000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [mmq_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [mmq_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]                    m_axis_tuser;

    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] status_seen;

    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          words_sent;
    int          cycle_count;
    int          phase;
    int          burst;
    int          stop_at;
    logic [mmq_pkg::MB_W-1:0]   box;
    logic [mmq_pkg::DATA_W-1:0] clock_secs;

    mailbox_message_queue_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mmq_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_user    (s_axis_tuser),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .i_rsp_user    (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_seen (status_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d result words outstanding",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Time mostly creeps forward, with an occasional jump anywhere in range.
    function automatic logic [mmq_pkg::DATA_W-1:0] next_stamp();
        if ($urandom_range(49) == 0)
            clock_secs = $urandom;
        else
            clock_secs = clock_secs + mmq_pkg::DATA_W'($urandom_range(0, 3));
        return clock_secs;
    endfunction

    function automatic logic [mmq_pkg::DATA_W-1:0] pick_payload();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [mmq_pkg::MB_W-1:0] pick_mailbox();
        if ($urandom_range(99) < 12)
            return mmq_pkg::MB_W'($urandom_range(mmq_pkg::MAILBOXES,
                                                 (1 << mmq_pkg::MB_W) - 1));
        return mmq_pkg::MB_W'($urandom_range(0, mmq_pkg::MAILBOXES - 1));
    endfunction

    // Offers one request word and returns in the step where it was taken.
    task automatic send_request(input mmq_pkg::t_cmd op,
                                input logic [mmq_pkg::PID_W-1:0] pid,
                                input logic [mmq_pkg::MB_W-1:0] mb,
                                input logic [mmq_pkg::DATA_W-1:0] data,
                                input logic [mmq_pkg::DATA_W-1:0] now);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {now, data, mb, pid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
    endtask

    initial begin
        s_axis_tvalid     <= 1'b0;
        s_axis_tdata      <= '0;
        s_axis_tuser      <= mmq_pkg::CMD_SEND;
        i_rst_n           <= 1'b0;
        sender_idle_pct   = 29;
        receiver_idle_pct = 79;
        clock_secs        = 32'h0000_1000;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Receiver blocks, then a send with all-ones pid, payload and stamp wakes it.
        send_request(mmq_pkg::CMD_RECV, '0, '0, '0, 32'h0000_0010);
        send_request(mmq_pkg::CMD_SEND, '1, '0, '1, '1);
        // Plain queue with all-zero fields, then a receive with all-ones pid, payload and stamp.
        send_request(mmq_pkg::CMD_SEND, '0, mmq_pkg::MB_W'(1), '0, '0);
        send_request(mmq_pkg::CMD_RECV, '1, mmq_pkg::MB_W'(1), '1, '1);
        // Mailbox numbers past the last one.
        send_request(mmq_pkg::CMD_SEND, 5'd7, mmq_pkg::MB_W'(mmq_pkg::MAILBOXES),
                     32'h1234_5678, next_stamp());
        send_request(mmq_pkg::CMD_RECV, 5'd8, '1, 32'h8765_4321, next_stamp());
        // The same pid waits twice and is woken twice, in order.
        send_request(mmq_pkg::CMD_RECV, 5'd9, mmq_pkg::MB_W'(2), '0, next_stamp());
        send_request(mmq_pkg::CMD_RECV, 5'd9, mmq_pkg::MB_W'(2), '0, next_stamp());
        send_request(mmq_pkg::CMD_SEND, 5'd3, mmq_pkg::MB_W'(2), 32'hA5A5_A5A5,
                     next_stamp());
        send_request(mmq_pkg::CMD_SEND, 5'd4, mmq_pkg::MB_W'(2), 32'h5A5A_5A5A,
                     next_stamp());
        // Ring order on the highest mailbox, then a block and a wake-up there.
        box = mmq_pkg::MB_W'(mmq_pkg::MAILBOXES - 1);
        send_request(mmq_pkg::CMD_SEND, 5'd17, box, 32'hDEAD_BEEF, next_stamp());
        send_request(mmq_pkg::CMD_SEND, 5'd18, box, 32'hCAFE_F00D, next_stamp());
        send_request(mmq_pkg::CMD_RECV, 5'd20, box, '0, next_stamp());
        send_request(mmq_pkg::CMD_RECV, 5'd21, box, '0, next_stamp());
        send_request(mmq_pkg::CMD_RECV, 5'd22, box, '0, next_stamp());
        send_request(mmq_pkg::CMD_SEND, 5'd23, box, 32'h0F0F_0F0F, next_stamp());

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct   = 29;
                    receiver_idle_pct = 79;
                end
                1: begin
                    sender_idle_pct   = 79;
                    receiver_idle_pct = 29;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            stop_at = words_sent + WORDS_PER_PHASE;
            while (words_sent < stop_at) begin
                case ($urandom_range(9))
                    // Send bursts push a ring to full when nobody waits.
                    0, 1: begin
                        box   = mmq_pkg::MB_W'($urandom_range(0, mmq_pkg::MAILBOXES - 1));
                        burst = $urandom_range(1, 24);
                        repeat (burst)
                            send_request(mmq_pkg::CMD_SEND, mmq_pkg::PID_W'($urandom), box,
                                         pick_payload(), next_stamp());
                    end
                    // Long receive bursts drain a ring and then fill its waiter queue.
                    2: begin
                        box   = mmq_pkg::MB_W'($urandom_range(0, mmq_pkg::MAILBOXES - 1));
                        burst = $urandom_range(10, 50);
                        repeat (burst)
                            send_request(mmq_pkg::CMD_RECV, mmq_pkg::PID_W'($urandom), box,
                                         pick_payload(), next_stamp());
                    end
                    default:
                        send_request(mmq_pkg::t_cmd'($urandom_range(1)),
                                     mmq_pkg::PID_W'($urandom), pick_mailbox(),
                                     pick_payload(), next_stamp());
                endcase
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d request words over three idling mixes; checked %0d result words.",
                 words_sent, checked);
        $display("Status codes seen (bit per code, code 0 on the right): %b", status_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
